@@ design/cbt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier tessellator.
// No dependencies.
package cbt_pkg;

  localparam int COORD_BITS = 16;
  localparam int RES_BITS   = 6;
  localparam logic [RES_BITS-1:0] RES_RESET = 6'd16;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t left_x;
    coord_t left_y;
    coord_t left_z;
    coord_t right_x;
    coord_t right_y;
    coord_t right_z;
    logic   last_node;
  } node_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   run_end;
  } point_t;

  // Four control points, three coordinates each, plus the index of the last step.
  typedef struct packed {
    logic [3:0][2:0][COORD_BITS-1:0] pt;
    logic [RES_BITS-1:0]             last_step;
  } seg_cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

endpackage

@@ design/cbt_fifo.sv @@
`timescale 1ns / 1ps
// Short segment queue between the front and the back of the tessellator.
// Depends on cbt_pkg for the status struct.
module cbt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    din,
  input  logic                pop,
  output cbt_pkg::fifo_stat_t stat,
  output logic [WIDTH-1:0]    dout
);
  import cbt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign dout       = mem[rd_ptr];
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & stat.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ design/cbt_div.sv @@
`timescale 1ns / 1ps
// Bit-serial divider: 2^TF / divisor, quotient and remainder, one bit a cycle.
// Depends on cbt_pkg for the resolution width.
module cbt_div #(
  parameter int TF = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cbt_pkg::RES_BITS-1:0] divisor,
  output logic                         busy,
  output logic [TF:0]                  quo,
  output logic [cbt_pkg::RES_BITS-1:0] rem
);
  import cbt_pkg::*;

  localparam int CNTW = $clog2(TF + 1);

  logic [CNTW-1:0]   cnt;
  logic [RES_BITS:0] part;
  logic [RES_BITS:0] shifted;
  logic              ge;

  assign shifted = {part[RES_BITS-1:0], (cnt == CNTW'(TF))};
  assign ge      = (shifted >= {1'b0, divisor});
  assign rem     = part[RES_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(TF);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= '0;
    end else if (busy) begin
      part <= ge ? shifted - {1'b0, divisor} : shifted;
      quo  <= {quo[TF-1:0], ge};
    end
  end

endmodule

@@ design/cbt_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts nodes, keeps the previous node, builds segment commands.
// Depends on cbt_pkg.
module cbt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cbt_pkg::node_t               in_data,
  input  logic                         hold,
  input  logic                         full,
  input  logic [cbt_pkg::RES_BITS-1:0] res_eff,
  output logic                         push,
  output cbt_pkg::seg_cmd_t            cmd
);
  import cbt_pkg::*;

  logic [2:0][COORD_BITS-1:0] prev_pos;
  logic [2:0][COORD_BITS-1:0] prev_right;
  logic                       have_prev;
  logic                       acc;
  logic [2:0][COORD_BITS-1:0] cur_pos;
  logic [2:0][COORD_BITS-1:0] cur_left;

  assign in_stall = hold | full;
  assign acc      = in_valid & ~in_stall;
  assign push     = acc & (have_prev | in_data.last_node);
  assign cur_pos  = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign cur_left = {in_data.left_z, in_data.left_y, in_data.left_x};

  always_comb begin
    cmd.pt[3] = cur_pos;
    if (have_prev) begin
      cmd.pt[0]     = prev_pos;
      cmd.pt[1]     = prev_right;
      cmd.pt[2]     = cur_left;
      cmd.last_step = in_data.last_node ? res_eff : res_eff - 1'b1;
    end else begin
      cmd.pt[0]     = cur_pos;
      cmd.pt[1]     = cur_pos;
      cmd.pt[2]     = cur_pos;
      cmd.last_step = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (acc) begin
      have_prev <= ~in_data.last_node;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_data.last_node) begin
      prev_pos   <= cur_pos;
      prev_right <= {in_data.right_z, in_data.right_y, in_data.right_x};
    end
  end

endmodule

@@ design/cbt_back.sv @@
`timescale 1ns / 1ps
// Back end: steps t over a segment and evaluates Bernstein sums in a pipeline.
// Depends on cbt_pkg.
module cbt_back #(
  parameter int TF = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [TF:0]                  q_step,
  input  logic [cbt_pkg::RES_BITS-1:0] r_step,
  input  logic [cbt_pkg::RES_BITS-1:0] res_eff,
  input  cbt_pkg::fifo_stat_t          fstat,
  input  cbt_pkg::seg_cmd_t            fdata,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cbt_pkg::point_t              out_data
);
  import cbt_pkg::*;

  localparam int TB = TF + 1;
  localparam int W  = 3 * TF + 1;
  localparam int PW = W + 1 + COORD_BITS;
  localparam int SW = PW + 2;

  typedef logic [3:0][2:0][COORD_BITS-1:0] pts_t;

  logic              en;
  logic              busy;
  seg_cmd_t          cur;
  logic [RES_BITS-1:0] step;
  logic [TB-1:0]     t;
  logic [RES_BITS-1:0] racc;
  logic [RES_BITS:0] rsum;
  logic              wrap;
  logic              issue;
  logic [TB-1:0]     u;

  logic              v1, v2, v3;
  logic              e1, e2, e3;
  pts_t              p1, p2;
  logic [2*TB-1:0]   uu, tt;
  logic [TB-1:0]     u1, t1;
  logic [3:0][W-1:0] w2;
  logic [3:0][2:0][PW-1:0] prod3;

  logic [3*TB-1:0]   m0, m1, m2, m3;
  logic [3*TB+1:0]   m1x3, m2x3;
  logic [2:0][SW-1:0] sum;

  assign en    = ~(out_valid & out_stall);
  assign pop   = ~busy & fstat.valid;
  assign issue = busy & en;
  assign u     = TB'(1) << TF;
  assign rsum  = {1'b0, racc} + {1'b0, r_step};
  assign wrap  = (rsum >= {1'b0, res_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (issue && step == cur.last_step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= fdata;
      step <= '0;
      t    <= '0;
      racc <= '0;
    end else if (issue) begin
      step <= step + 1'b1;
      t    <= t + q_step + TB'(wrap);
      racc <= wrap ? RES_BITS'(rsum - {1'b0, res_eff}) : rsum[RES_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_comb begin
    m0   = (3*TB)'(uu) * (3*TB)'(u1);
    m1   = (3*TB)'(uu) * (3*TB)'(t1);
    m2   = (3*TB)'(tt) * (3*TB)'(u1);
    m3   = (3*TB)'(tt) * (3*TB)'(t1);
    m1x3 = {2'b00, m1} + {1'b0, m1, 1'b0};
    m2x3 = {2'b00, m2} + {1'b0, m2, 1'b0};
    for (int c = 0; c < 3; c++) begin
      sum[c] = (SW'(1) << (3 * TF - 1));
      for (int j = 0; j < 4; j++) begin
        sum[c] = sum[c] + {{(SW - PW){prod3[j][c][PW-1]}}, prod3[j][c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= u - t;
      t1 <= t;
      uu <= (u - t) * (u - t);
      tt <= t * t;
      p1 <= cur.pt;
      e1 <= (step == cur.last_step);

      w2[0] <= m0[W-1:0];
      w2[1] <= m1x3[W-1:0];
      w2[2] <= m2x3[W-1:0];
      w2[3] <= m3[W-1:0];
      p2    <= p1;
      e2    <= e1;

      for (int j = 0; j < 4; j++) begin
        for (int c = 0; c < 3; c++) begin
          prod3[j][c] <= $signed({{(PW - W){1'b0}}, w2[j]}) *
                         $signed({{(PW - COORD_BITS){p2[j][c][COORD_BITS-1]}}, p2[j][c]});
        end
      end
      e3 <= e2;

      out_data.point_x <= sum[0][3*TF +: COORD_BITS];
      out_data.point_y <= sum[1][3*TF +: COORD_BITS];
      out_data.point_z <= sum[2][3*TF +: COORD_BITS];
      out_data.run_end <= e3;
    end
  end

endmodule

@@ design/cubic_bezier_tessellator.sv @@
`timescale 1ns / 1ps
// Cubic Bezier tessellator: node input, point output, resolution register.
// Instantiates cbt_front, cbt_fifo, cbt_div and cbt_back; depends on cbt_pkg.
//
// Usage:
//   in channel  : one curve node per transfer (in_valid / in_stall).
//   out channel : one curve point per transfer (out_valid / out_stall);
//                 run_end marks the last point a node causes.
//   cfg channel : writes the resolution register (cfg_valid / cfg_ready),
//                 always ready; write only while the block is idle.
// A node that opens a curve yields nothing, unless it also closes it, in which
// case its position comes out as one point. Every later node yields resolution
// points, one more when it closes the curve.
// Throughput: one point per cycle from the evaluation pipeline while out_stall
// is low, plus a step per node to load the segment, in which no point issues.
// A node's first point passes the segment queue, the segment register and the
// pipeline registers behind v1, v2, v3 and out_valid.
// After reset, and after every resolution write, the step divider runs; in_stall
// is high from the pending start until the divider is no longer busy.
// out_stall, while out_valid is high, freezes the whole back pipeline; the
// segment queue then fills and raises in_stall.
module cubic_bezier_tessellator #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cbt_pkg::node_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cbt_pkg::point_t              out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cbt_pkg::RES_BITS-1:0] cfg_data
);
  import cbt_pkg::*;

  logic [RES_BITS-1:0]  resolution;
  logic [RES_BITS-1:0]  res_eff;
  logic                 start_pending;
  logic                 div_busy;
  logic [T_FRAC_BITS:0] q_step;
  logic [RES_BITS-1:0]  r_step;
  logic                 push;
  logic                 pop;
  seg_cmd_t             cmd_in;
  seg_cmd_t             cmd_out;
  fifo_stat_t           fstat;
  logic                 hold;

  assign cfg_ready = 1'b1;
  assign res_eff   = (resolution == '0) ? RES_BITS'(1) : resolution;
  assign hold      = start_pending | div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution    <= RES_RESET;
      start_pending <= 1'b1;
    end else begin
      start_pending <= cfg_valid & cfg_ready;
      if (cfg_valid && cfg_ready) begin
        resolution <= cfg_data;
      end
    end
  end

  cbt_div #(.TF(T_FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start_pending),
    .divisor (res_eff),
    .busy    (div_busy),
    .quo     (q_step),
    .rem     (r_step)
  );

  cbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .hold     (hold),
    .full     (fstat.full),
    .res_eff  (res_eff),
    .push     (push),
    .cmd      (cmd_in)
  );

  cbt_fifo #(.WIDTH($bits(seg_cmd_t)), .DEPTH(2)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .pop  (pop),
    .stat (fstat),
    .dout (cmd_out)
  );

  cbt_back #(.TF(T_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_step    (q_step),
    .r_step    (r_step),
    .res_eff   (res_eff),
    .fstat     (fstat),
    .fdata     (cmd_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_transfer_while_div: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall && (div_busy || start_pending)))
    else $error("node transfer while step divider busy");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fstat.full)
    else $error("segment queue overflow");

  a_div_follows_write: assert property (@(posedge clk) disable iff (rst)
    start_pending |=> div_busy)
    else $error("step divider did not start after resolution write");

endmodule
